// ----- hdl/gps_pkg.sv -----
// Shared types and constants of the polar-method Gaussian sampler.
// Used by the front end, the queue, the back end and the top level.
package gps_pkg;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_MEAN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPREAD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEEP   = 2'd2;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    // ln 2 as an unsigned Q0.32 constant.
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;

    typedef struct packed {
        logic signed [31:0] mean;
        logic [23:0]        spread;
        logic               keep;
    } t_cfg;

    // Magnitudes |v| in Q1.30 with their signs.
    typedef struct packed {
        logic [30:0] a1;
        logic        n1;
        logic [30:0] a2;
        logic        n2;
    } t_side;

    // One accepted pair as it waits between front and back.
    typedef struct packed {
        t_side       side;
        logic [59:0] s;
    } t_pair;

endpackage

// ----- hdl/gps_front.sv -----
// Front end: maps the uniform pair to signed Q1.30 values, squares them and
// drops pairs outside the open unit circle. Depends on gps_pkg.
module gps_front #(
    parameter int UNIFORM_BITS = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  logic [31:0]     i_uniform_first,
    input  logic [31:0]     i_uniform_second,
    input  logic            i_full,
    output logic            o_push,
    output gps_pkg::t_pair  o_data
);

    localparam int SHR = (UNIFORM_BITS >= 31) ? UNIFORM_BITS - 31 : 0;
    localparam int SHL = (UNIFORM_BITS < 31) ? 31 - UNIFORM_BITS : 0;
    localparam logic [63:0] UMASK = (64'd1 << UNIFORM_BITS) - 64'd1;

    function automatic logic [31:0] to_v(input logic [31:0] u);
        logic [63:0] uw;
        logic [63:0] w64;
        logic [30:0] w;
        uw = {32'd0, u} & UMASK;
        w64 = (UNIFORM_BITS >= 31) ? (uw >> SHR) : (uw << SHL);
        w = w64[30:0];
        if (w >= 31'h4000_0000) begin
            return {1'b0, w - 31'h4000_0000};
        end
        return {1'b1, 31'h4000_0000 - w};
    endfunction

    logic         en;
    logic         r1_v, r2_v;
    gps_pkg::t_side r1_side, r2_side;
    logic [61:0]  r2_sq1, r2_sq2;
    logic [61:0]  sum;
    logic [31:0]  v1, v2;

    assign en      = !i_full;
    assign o_stall = i_full;
    assign v1      = to_v(i_uniform_first);
    assign v2      = to_v(i_uniform_second);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_side <= '{a1: v1[30:0], n1: v1[31], a2: v2[30:0], n2: v2[31]};
            r2_side <= r1_side;
            r2_sq1  <= 62'(r1_side.a1) * 62'(r1_side.a1);
            r2_sq2  <= 62'(r1_side.a2) * 62'(r1_side.a2);
        end
    end

    // The pair goes on only when 0 < s < 1.
    assign sum         = r2_sq1 + r2_sq2;
    assign o_push      = en && r2_v && (sum != 62'd0) && (sum[61:60] == 2'b00);
    assign o_data.side = r2_side;
    assign o_data.s    = sum[59:0];

endmodule

// ----- hdl/gps_fifo.sv -----
// Short queue of accepted pairs between the front and back ends.
// Depends on gps_pkg for the entry type and depth.
module gps_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  gps_pkg::t_pair  i_data,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output gps_pkg::t_pair  o_data
);

    gps_pkg::t_pair r_mem [0:gps_pkg::QUEUE_DEPTH-1];
    logic [gps_pkg::QPTR_W-1:0] r_wr, r_rd;
    logic [gps_pkg::QPTR_W:0]   r_count;

    assign o_full  = (r_count == (gps_pkg::QPTR_W + 1)'(gps_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ----- hdl/gps_back.sv -----
// Back end: logarithm by repeated squaring, two square roots, two dividers,
// scaling, rounding, offset and saturation, then the result serializer.
// Depends on gps_pkg.
module gps_back #(
    parameter int OUT_FRAC_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  gps_pkg::t_cfg       i_cfg,
    input  logic                i_q_valid,
    input  gps_pkg::t_pair      i_q_data,
    output logic                o_q_pop,
    output logic                o_valid,
    input  logic                i_stall,
    output logic signed [31:0]  o_normal_value,
    output logic                o_last_of_pair,
    output logic                o_clipped
);

    localparam int LOG_STEPS  = 32;
    localparam int SQS_STEPS  = 30;
    localparam int G_STEPS    = 32;
    localparam int DIV_STEPS  = 31;
    localparam int SH         = 48 - OUT_FRAC_BITS;
    localparam logic [61:0] ROUND_C = 62'd1 << (SH - 1);

    typedef struct packed {
        gps_pkg::t_side side;
        logic [63:0]    sn;
        logic [63:0]    sr;
        logic [30:0]    x;
        logic [31:0]    f;
        logic [5:0]     k;
    } t_lstage;

    typedef struct packed {
        gps_pkg::t_side side;
        logic [29:0]    root_s;
        logic [63:0]    gn;
        logic [63:0]    gr;
        logic [29:0]    rem1;
        logic [30:0]    q1;
        logic [29:0]    rem2;
        logic [30:0]    q2;
    } t_gstage;

    function automatic logic [31:0] log_step(input logic [30:0] x);
        logic [61:0] sq;
        logic [31:0] y;
        sq = 62'(x) * 62'(x);
        y = sq[61:30];
        if (y[31]) begin
            return {1'b1, y[31:1]};
        end
        return {1'b0, y[30:0]};
    endfunction

    function automatic logic [127:0] sqrt_step(input logic [63:0] n, input logic [63:0] res,
                                               input logic [63:0] b);
        if (n >= res + b) begin
            return {n - (res + b), (res >> 1) + b};
        end
        return {n, res >> 1};
    endfunction

    function automatic logic [30:0] div_step(input logic [29:0] rem, input logic inbit,
                                             input logic [29:0] d);
        logic [30:0] sh;
        sh = {rem, inbit};
        if (sh >= {1'b0, d}) begin
            return {1'b1, 30'(sh - {1'b0, d})};
        end
        return {1'b0, sh[29:0]};
    endfunction

    function automatic logic [32:0] finish(input logic [36:0] mag, input logic neg,
                                           input logic signed [31:0] mean);
        logic signed [39:0] m;
        logic signed [39:0] v;
        m = neg ? -$signed({3'b000, mag}) : $signed({3'b000, mag});
        v = m + {{8{mean[31]}}, mean};
        if (v > 40'sh00_7FFF_FFFF) begin
            return {1'b1, 32'h7FFF_FFFF};
        end
        if (v < -40'sh00_8000_0000) begin
            return {1'b1, 32'h8000_0000};
        end
        return {1'b0, v[31:0]};
    endfunction

    logic en;

    // Normalization stages.
    logic           r0_v, r1_v;
    gps_pkg::t_side r0_side, r1_side;
    logic [59:0]    r0_s, r1_s;
    logic           r0_hiany;
    logic [4:0]     r0_hipos, r0_lopos;
    logic [30:0]    r1_x;
    logic [5:0]     r1_k;
    logic [4:0]     hipos, lopos;
    logic [5:0]     p;
    logic [59:0]    y;

    always_comb begin
        hipos = '0;
        lopos = '0;
        for (int i = 0; i < 30; i++) begin
            if (i_q_data.s[30 + i]) begin
                hipos = 5'(i);
            end
            if (i_q_data.s[i]) begin
                lopos = 5'(i);
            end
        end
    end

    assign p = r0_hiany ? (6'd30 + {1'b0, r0_hipos}) : {1'b0, r0_lopos};
    assign y = r0_s << (6'd59 - p);

    // Log and square-root-of-s stages.
    t_lstage rl [0:LOG_STEPS-1];
    t_lstage li [0:LOG_STEPS-1];
    t_lstage nl [0:LOG_STEPS-1];
    logic    rl_v [0:LOG_STEPS-1];
    logic    li_v [0:LOG_STEPS-1];

    always_comb begin
        li[0]   = '{side: r1_side, sn: {4'd0, r1_s}, sr: 64'd0, x: r1_x, f: 32'd0, k: r1_k};
        li_v[0] = r1_v;
        for (int j = 1; j < LOG_STEPS; j++) begin
            li[j]   = rl[j-1];
            li_v[j] = rl_v[j-1];
        end
    end

    always_comb begin
        logic [31:0]  ls;
        logic [127:0] ss;
        for (int j = 0; j < LOG_STEPS; j++) begin
            nl[j] = li[j];
            ls = log_step(li[j].x);
            nl[j].x = ls[30:0];
            nl[j].f = {li[j].f[30:0], ls[31]};
            if (j < SQS_STEPS) begin
                ss = sqrt_step(li[j].sn, li[j].sr, 64'd1 << (58 - 2 * j));
                nl[j].sn = ss[127:64];
                nl[j].sr = ss[63:0];
            end
        end
    end

    // Conversion of the logarithm to -2 ln s.
    logic           rt1_v, rt2_v;
    gps_pkg::t_side rt1_side, rt2_side;
    logic [29:0]    rt1_rs, rt2_rs;
    logic [37:0]    rt1_hp;
    logic [63:0]    rt1_lp;
    logic [39:0]    rt2_g;
    logic [37:0]    t;

    assign t = {rl[LOG_STEPS-1].k, 32'd0} - {6'd0, rl[LOG_STEPS-1].f};

    // Root of -2 ln s and the two divisions by the root of s.
    t_gstage rg [0:G_STEPS-1];
    t_gstage gi [0:G_STEPS-1];
    t_gstage ng [0:G_STEPS-1];
    logic    rg_v [0:G_STEPS-1];
    logic    gi_v [0:G_STEPS-1];

    always_comb begin
        gi[0] = '{side: rt2_side, root_s: rt2_rs, gn: {rt2_g[39:0], 24'd0}, gr: 64'd0,
                  rem1: rt2_side.a1[30:1], q1: 31'd0, rem2: rt2_side.a2[30:1], q2: 31'd0};
        gi_v[0] = rt2_v;
        for (int j = 1; j < G_STEPS; j++) begin
            gi[j]   = rg[j-1];
            gi_v[j] = rg_v[j-1];
        end
    end

    always_comb begin
        logic [127:0] ss;
        logic [30:0]  d1, d2;
        for (int j = 0; j < G_STEPS; j++) begin
            ng[j] = gi[j];
            ss = sqrt_step(gi[j].gn, gi[j].gr, 64'd1 << (62 - 2 * j));
            ng[j].gn = ss[127:64];
            ng[j].gr = ss[63:0];
            if (j < DIV_STEPS) begin
                d1 = div_step(gi[j].rem1, (j == 0) ? gi[j].side.a1[0] : 1'b0, gi[j].root_s);
                d2 = div_step(gi[j].rem2, (j == 0) ? gi[j].side.a2[0] : 1'b0, gi[j].root_s);
                ng[j].rem1 = d1[29:0];
                ng[j].q1   = {gi[j].q1[29:0], d1[30]};
                ng[j].rem2 = d2[29:0];
                ng[j].q2   = {gi[j].q2[29:0], d2[30]};
            end
        end
    end

    // Products, rounding and the final sum.
    logic        rm1_v, rm2_v, rr_v, rf_v;
    logic        rm1_n1, rm1_n2, rm2_n1, rm2_n2, rr_n1, rr_n2;
    logic [62:0] prod1, prod2;
    logic [36:0] rm1_z1, rm1_z2;
    logic [60:0] rm2_p1, rm2_p2;
    logic [36:0] rr_m1, rr_m2;
    logic [61:0] sh1, sh2;
    logic [32:0] fin1, fin2;
    logic [31:0] rf_val1, rf_val2;
    logic        rf_clip1, rf_clip2;

    assign prod1 = 63'(rg[G_STEPS-1].q1) * 63'(rg[G_STEPS-1].gr[31:0]);
    assign prod2 = 63'(rg[G_STEPS-1].q2) * 63'(rg[G_STEPS-1].gr[31:0]);
    assign sh1   = ({1'b0, rm2_p1} + ROUND_C) >> SH;
    assign sh2   = ({1'b0, rm2_p2} + ROUND_C) >> SH;
    assign fin1  = finish(rr_m1, rr_n1, i_cfg.mean);
    assign fin2  = finish(rr_m2, rr_n2, i_cfg.mean);

    assign o_q_pop = en && i_q_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v  <= 1'b0;
            r1_v  <= 1'b0;
            rt1_v <= 1'b0;
            rt2_v <= 1'b0;
            rm1_v <= 1'b0;
            rm2_v <= 1'b0;
            rr_v  <= 1'b0;
            rf_v  <= 1'b0;
            for (int j = 0; j < LOG_STEPS; j++) begin
                rl_v[j] <= 1'b0;
            end
            for (int j = 0; j < G_STEPS; j++) begin
                rg_v[j] <= 1'b0;
            end
        end else if (en) begin
            r0_v  <= i_q_valid;
            r1_v  <= r0_v;
            for (int j = 0; j < LOG_STEPS; j++) begin
                rl_v[j] <= li_v[j];
            end
            rt1_v <= rl_v[LOG_STEPS-1];
            rt2_v <= rt1_v;
            for (int j = 0; j < G_STEPS; j++) begin
                rg_v[j] <= gi_v[j];
            end
            rm1_v <= rg_v[G_STEPS-1];
            rm2_v <= rm1_v;
            rr_v  <= rm2_v;
            rf_v  <= rr_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_side  <= i_q_data.side;
            r0_s     <= i_q_data.s;
            r0_hiany <= |i_q_data.s[59:30];
            r0_hipos <= hipos;
            r0_lopos <= lopos;
            r1_side  <= r0_side;
            r1_s     <= r0_s;
            r1_x     <= y[59:29];
            r1_k     <= 6'd60 - p;
            for (int j = 0; j < LOG_STEPS; j++) begin
                rl[j] <= nl[j];
            end
            rt1_side <= rl[LOG_STEPS-1].side;
            rt1_rs   <= rl[LOG_STEPS-1].sr[29:0];
            rt1_hp   <= 38'(t[37:32]) * 38'(gps_pkg::LN2_Q32);
            rt1_lp   <= 64'(t[31:0]) * 64'(gps_pkg::LN2_Q32);
            rt2_side <= rt1_side;
            rt2_rs   <= rt1_rs;
            rt2_g    <= {1'b0, rt1_hp, 1'b0} + {7'd0, rt1_lp[63:31]};
            for (int j = 0; j < G_STEPS; j++) begin
                rg[j] <= ng[j];
            end
            rm1_z1   <= prod1[62:26];
            rm1_z2   <= prod2[62:26];
            rm1_n1   <= rg[G_STEPS-1].side.n1;
            rm1_n2   <= rg[G_STEPS-1].side.n2;
            rm2_p1   <= 61'(rm1_z1) * 61'(i_cfg.spread);
            rm2_p2   <= 61'(rm1_z2) * 61'(i_cfg.spread);
            rm2_n1   <= rm1_n1;
            rm2_n2   <= rm1_n2;
            rr_m1    <= sh1[36:0];
            rr_m2    <= sh2[36:0];
            rr_n1    <= rm2_n1;
            rr_n2    <= rm2_n2;
            rf_val1  <= fin1[31:0];
            rf_clip1 <= fin1[32];
            rf_val2  <= fin2[31:0];
            rf_clip2 <= fin2[32];
        end
    end

    // Serializer: the first item goes out; with keep set, the second waits in a pending slot.
    logic               r_out_valid, r_pend_valid;
    logic signed [31:0] r_out_value;
    logic               r_out_last, r_out_clip;
    logic [31:0]        r_pend_value;
    logic               r_pend_clip;
    logic               out_free;

    assign out_free = !r_out_valid || !i_stall;
    assign en       = out_free && !r_pend_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else if (out_free) begin
            if (r_pend_valid) begin
                r_out_valid  <= 1'b1;
                r_pend_valid <= 1'b0;
            end else begin
                r_out_valid  <= rf_v;
                r_pend_valid <= rf_v && i_cfg.keep;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_pend_valid) begin
                r_out_value <= r_pend_value;
                r_out_last  <= 1'b1;
                r_out_clip  <= r_pend_clip;
            end else begin
                r_out_value  <= rf_val1;
                r_out_last   <= !i_cfg.keep;
                r_out_clip   <= rf_clip1;
                r_pend_value <= rf_val2;
                r_pend_clip  <= rf_clip2;
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_normal_value = r_out_value;
    assign o_last_of_pair = r_out_last;
    assign o_clipped      = r_out_clip;

endmodule

// ----- hdl/gaussian_polar_sampler_top.sv -----
// Top level of the polar-method Gaussian sampler: configuration registers,
// front end, pair queue and back end. Depends on gps_pkg and all submodules.
// Throughput: one pair per cycle with keep at 0 while the output does not stall; with
// keep at 1 no new pair is taken while the second item waits for the output.
// Reset clears the pipeline, the queue and the serializer, and loads register defaults.
module gaussian_polar_sampler_top #(
    parameter int UNIFORM_BITS  = 32,
    parameter int OUT_FRAC_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [gps_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [31:0]                       i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [31:0]                       i_uniform_first,
    input  logic [31:0]                       i_uniform_second,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [31:0]                o_normal_value,
    output logic                              o_last_of_pair,
    output logic                              o_clipped
);

    // Configuration registers. The user must change them only while the block is idle; the
    // block does not enforce it, and the back end reads them directly where each one is used.
    gps_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mean   <= 32'sd0;
            r_cfg.spread <= 24'd65536;
            r_cfg.keep   <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                gps_pkg::REG_MEAN:   r_cfg.mean   <= $signed(i_cfg_data);
                gps_pkg::REG_SPREAD: r_cfg.spread <= i_cfg_data[23:0];
                gps_pkg::REG_KEEP:   r_cfg.keep   <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    logic           q_push, q_full, q_pop, q_valid;
    gps_pkg::t_pair q_in, q_out;

    // The front end maps and squares the pair, and drops it when it lies
    // outside the open unit circle; surviving pairs enter the queue.
    gps_front #(
        .UNIFORM_BITS(UNIFORM_BITS)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_in_valid),
        .o_stall          (o_in_stall),
        .i_uniform_first  (i_uniform_first),
        .i_uniform_second (i_uniform_second),
        .i_full           (q_full),
        .o_push           (q_push),
        .o_data           (q_in)
    );

    // The queue lets the front end keep taking items while the output stalls, until it fills.
    gps_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_out)
    );

    // The back end forms both variates of a pair and sends out the first, and with keep set the second after it.
    gps_back #(
        .OUT_FRAC_BITS(OUT_FRAC_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_q_valid      (q_valid),
        .i_q_data       (q_out),
        .o_q_pop        (q_pop),
        .o_valid        (o_out_valid),
        .i_stall        (i_out_stall),
        .o_normal_value (o_normal_value),
        .o_last_of_pair (o_last_of_pair),
        .o_clipped      (o_clipped)
    );

endmodule
